/* rtl/bpqw_pkg.sv */
// ----------------------------------------------------------------------------
// bpqw_pkg
// Shared types and constants for the bounded priority queue with watermarks.
// ----------------------------------------------------------------------------
package bpqw_pkg;

  // Store depth default and fixed field widths
  localparam int DEPTH_DEF = 16;
  localparam int PRI_W     = 8;
  localparam int PAY_W     = 32;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK    = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [CFG_W-1:0] HIGH_MARK_RST   = 5'd12;
  localparam logic [CFG_W-1:0] LOW_MARK_RST    = 5'd4;

  // Operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Input request
  typedef struct packed {
    logic             func;
    logic [PRI_W-1:0] priority_req;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  // Result
  typedef struct packed {
    logic             ok;
    logic [PAY_W-1:0] out_payload;
    logic [PRI_W-1:0] out_priority;
    logic             full_event;
    logic             empty_event;
    logic [CNT_W-1:0] count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
  } ctrl_cmd_t;

endpackage

/* rtl/bounded_priority_queue_watermarks.sv */
// ----------------------------------------------------------------------------
// bounded_priority_queue_watermarks
// Bounded priority message queue with full and empty watermark events.
// ----------------------------------------------------------------------------
// Each request is captured in the request register, then executed: every
// cell of the sorted store compares against the new priority and shifts in
// parallel, writing the result register. A result left stalled at the output
// holds the execute cycle until it is taken. Enqueue places the entry behind
// all entries of equal or higher priority and is refused at the capacity in
// use (max_entries, limited to DEPTH); dequeue returns the head entry.
// full_event flags an accepted enqueue that leaves the count at or above
// high_mark, empty_event a dequeue leaving it at or below low_mark.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
module bounded_priority_queue_watermarks #(
  parameter int DEPTH = bpqw_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bpqw_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bpqw_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [bpqw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpqw_pkg::CFG_W-1:0]      cfg_data
);

  bpqw_pkg::ctrl_cmd_t cmd;

  // Sequencer
  bpqw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store and result path
  bpqw_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* rtl/bpqw_ctrl.sv */
// ----------------------------------------------------------------------------
// bpqw_ctrl
// Sequencer: captures a request, then executes it once the result register
// is free, and tracks result validity.
// ----------------------------------------------------------------------------
module bpqw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bpqw_pkg::ctrl_cmd_t  cmd
);

  bpqw_pkg::state_t state;
  bpqw_pkg::state_t state_next;
  logic             out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpqw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bpqw_pkg::ST_IDLE: begin
        if (in_valid) state_next = bpqw_pkg::ST_EXEC;
      end
      bpqw_pkg::ST_EXEC: begin
        if (out_free) state_next = bpqw_pkg::ST_IDLE;
      end
      default: state_next = bpqw_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    in_stall    = 1'b1;
    case (state)
      bpqw_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      bpqw_pkg::ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/bpqw_datapath.sv */
// ----------------------------------------------------------------------------
// bpqw_datapath
// Configuration registers, request register, sorted compare-and-shift cell
// array and result register.
// ----------------------------------------------------------------------------
module bpqw_datapath #(
  parameter int DEPTH = bpqw_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpqw_pkg::ctrl_cmd_t                 cmd,
  input  bpqw_pkg::in_item_t                  in_data,
  output bpqw_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bpqw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpqw_pkg::CFG_W-1:0]          cfg_data
);

  localparam int HW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (HW > bpqw_pkg::CFG_W) ? HW : bpqw_pkg::CFG_W;

  logic [bpqw_pkg::CFG_W-1:0] max_entries;
  logic [bpqw_pkg::CFG_W-1:0] high_mark;
  logic [bpqw_pkg::CFG_W-1:0] low_mark;

  bpqw_pkg::in_item_t  in_q;
  bpqw_pkg::out_item_t res_next;
  bpqw_pkg::out_item_t out_q;

  logic [HW-1:0]    held;
  logic [HW-1:0]    held_next;
  logic [CMP_W-1:0] held_ext;
  logic [CMP_W-1:0] held_inc;
  logic [CMP_W-1:0] held_dec;
  logic             can_ins;
  logic             can_del;

  // Cells kept in descending priority; cell 0 is the head
  logic [bpqw_pkg::PRI_W-1:0] ent_pri      [DEPTH];
  logic [bpqw_pkg::PAY_W-1:0] ent_pay      [DEPTH];
  logic [bpqw_pkg::PRI_W-1:0] ent_pri_next [DEPTH];
  logic [bpqw_pkg::PAY_W-1:0] ent_pay_next [DEPTH];
  logic [DEPTH-1:0]           lt;
  logic [DEPTH-1:0]           lt_prev;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= bpqw_pkg::MAX_ENTRIES_RST;
      high_mark   <= bpqw_pkg::HIGH_MARK_RST;
      low_mark    <= bpqw_pkg::LOW_MARK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpqw_pkg::REG_MAX_ENTRIES: max_entries <= cfg_data;
        bpqw_pkg::REG_HIGH_MARK:   high_mark   <= cfg_data;
        bpqw_pkg::REG_LOW_MARK:    low_mark    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_q <= in_data;
  end

  // Occupancy tests
  assign held_ext = CMP_W'(held);
  assign held_inc = held_ext + CMP_W'(1);
  assign held_dec = held_ext - CMP_W'(1);
  assign can_ins  = (held_ext < CMP_W'(max_entries)) && (held_ext < CMP_W'(DEPTH));
  assign can_del  = (held != '0);

  // Per-cell compare: valid cell holding a strictly lower priority
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (HW'(i) < held) && (ent_pri[i] < in_q.priority_req);
    end
  end
  assign lt_prev = {lt[DEPTH-2:0], 1'b0};

  // Cell next values: insert opens a slot, remove shifts towards the head
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_pri_next[i] = ent_pri[i];
      ent_pay_next[i] = ent_pay[i];
      if (in_q.func == bpqw_pkg::FUNC_ENQ) begin
        if (lt_prev[i]) begin
          ent_pri_next[i] = ent_pri[(i == 0) ? 0 : i - 1];
          ent_pay_next[i] = ent_pay[(i == 0) ? 0 : i - 1];
        end else if (lt[i] || (HW'(i) == held)) begin
          ent_pri_next[i] = in_q.priority_req;
          ent_pay_next[i] = in_q.payload;
        end
      end else if (i < DEPTH - 1) begin
        ent_pri_next[i] = ent_pri[i + 1];
        ent_pay_next[i] = ent_pay[i + 1];
      end
    end
  end

  // Result and new count
  always_comb begin
    res_next  = '0;
    held_next = held;
    if (in_q.func == bpqw_pkg::FUNC_ENQ) begin
      if (can_ins) begin
        held_next           = HW'(held_inc);
        res_next.ok         = 1'b1;
        res_next.full_event = (held_inc >= CMP_W'(high_mark));
      end
    end else begin
      if (can_del) begin
        held_next            = HW'(held_dec);
        res_next.ok          = 1'b1;
        res_next.out_payload = ent_pay[0];
        res_next.out_priority = ent_pri[0];
        res_next.empty_event = (held_dec <= CMP_W'(low_mark));
      end
    end
    res_next.count = bpqw_pkg::CNT_W'(held_next);
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.exec) begin
      held <= held_next;
    end
  end

  // Cell array, only touched by an operation that succeeds
  always_ff @(posedge clk) begin
    if (cmd.exec && (in_q.func == bpqw_pkg::FUNC_ENQ ? can_ins : can_del)) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_pri[i] <= ent_pri_next[i];
        ent_pay[i] <= ent_pay_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) out_q <= res_next;
  end

  assign out_data = out_q;

endmodule

/* tb/sv/bounded_priority_queue_watermarks_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_watermarks_test
// Self-checking bench for the bounded priority queue. A queue-fed driver and
// a clocked monitor exercise enqueue and dequeue requests under random gaps
// and output stalls, across several register settings. Every result is
// compared field by field with a behavioural copy of the sorted store.
// ----------------------------------------------------------------------------
module bounded_priority_queue_watermarks_test;
  import bpqw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 80;
  localparam int PHASES     = 12;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Request and result bookkeeping
  in_item_t  queued_requests[$];
  out_item_t awaited_results[$];
  logic in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned idle_cycles = 0;
  int failures = 0;
  bit calm = 1'b0;

  // Behavioural copy of the sorted store and its registers
  logic [PRI_W-1:0] mirror_pri[DEPTH_DEF];
  logic [PAY_W-1:0] mirror_pay[DEPTH_DEF];
  int unsigned mirror_count = 0;
  logic [CFG_W-1:0] max_entries_q = MAX_ENTRIES_RST;
  logic [CFG_W-1:0] high_mark_q   = HIGH_MARK_RST;
  logic [CFG_W-1:0] low_mark_q    = LOW_MARK_RST;

  bounded_priority_queue_watermarks uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the mirrored store and return the result it gives
  function automatic out_item_t predict_queue_op(in_item_t req);
    out_item_t res;
    int unsigned cap;
    int unsigned slot;
    bit found;
    res = '0;
    cap = (max_entries_q > DEPTH_DEF) ? DEPTH_DEF : max_entries_q;
    if (req.func == FUNC_ENQ) begin
      if (mirror_count < cap) begin
        // new entry goes below every entry of equal or higher priority
        slot = mirror_count;
        found = 1'b0;
        for (int i = 0; i < mirror_count; i++) begin
          if (!found && req.priority_req <= mirror_pri[i]) begin
            slot = i;
            found = 1'b1;
          end
        end
        for (int i = mirror_count; i > slot; i--) begin
          mirror_pri[i] = mirror_pri[i-1];
          mirror_pay[i] = mirror_pay[i-1];
        end
        mirror_pri[slot] = req.priority_req;
        mirror_pay[slot] = req.payload;
        mirror_count++;
        res.ok = 1'b1;
        res.full_event = (mirror_count >= high_mark_q);
      end
    end else if (mirror_count > 0) begin
      mirror_count--;
      res.ok = 1'b1;
      res.out_payload  = mirror_pay[mirror_count];
      res.out_priority = mirror_pri[mirror_count];
      res.empty_event  = (mirror_count <= low_mark_q);
    end
    res.count = CNT_W'(mirror_count);
    return res;
  endfunction

  task automatic check_field(string name, logic [PAY_W-1:0] exp_v, logic [PAY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Monitor: checks results, predicts accepted requests, mirrors registers
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mirror_count = 0;
      max_entries_q = MAX_ENTRIES_RST;
      high_mark_q = HIGH_MARK_RST;
      low_mark_q = LOW_MARK_RST;
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", PAY_W'(want.ok), PAY_W'(out_data.ok));
          check_field("out_payload", want.out_payload, out_data.out_payload);
          check_field("out_priority", PAY_W'(want.out_priority),
                      PAY_W'(out_data.out_priority));
          check_field("full_event", PAY_W'(want.full_event), PAY_W'(out_data.full_event));
          check_field("empty_event", PAY_W'(want.empty_event),
                      PAY_W'(out_data.empty_event));
          check_field("count", PAY_W'(want.count), PAY_W'(out_data.count));
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(predict_queue_op(in_data));
      in_taken <= in_valid && !in_stall;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ENTRIES: max_entries_q = cfg_data;
          REG_HIGH_MARK:   high_mark_q = cfg_data;
          REG_LOW_MARK:    low_mark_q = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Driver: offers queued requests with random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid)
        send_gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      if (send_gap > 0 || queued_requests.size() == 0) begin
        if (send_gap > 0)
          send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= queued_requests.pop_front();
      end
    end
  end

  // Receiver: random stalls, plus a long hold when asked for
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      stall_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end
  end

  // Watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_request(logic func, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
    in_item_t req;
    req.func = func;
    req.priority_req = pri;
    req.payload = pay;
    queued_requests.push_back(req);
  endtask

  // Random requests; enq_pct steers the queue towards filling or draining
  task automatic add_random(int unsigned n, int unsigned enq_pct, bit narrow);
    repeat (n) begin
      add_request(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                  PRI_W'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                  $urandom);
    end
  endtask

  // Wait until every request is taken and every result has arrived
  task automatic settle();
    while (queued_requests.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_mark();
    case ($urandom_range(0, 5))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd16;
      default: return CFG_W'($urandom_range(0, 16));
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [CFG_W-1:0] cap_val;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: empty dequeue, extremes, equal priorities leave oldest first
    add_request(FUNC_DEQ, 8'd0, 32'h0);
    add_request(FUNC_ENQ, 8'd0, 32'h0);
    add_request(FUNC_ENQ, 8'd255, 32'hFFFF_FFFF);
    add_request(FUNC_ENQ, 8'd8, 32'hA1A1_0001);
    add_request(FUNC_ENQ, 8'd8, 32'hB2B2_0002);
    add_request(FUNC_ENQ, 8'd8, 32'hC3C3_0003);
    add_request(FUNC_ENQ, 8'd255, 32'h5A5A_5A5A);
    repeat (7) add_request(FUNC_DEQ, 8'hFF, 32'hFFFF_FFFF);
    settle();

    // Zero capacity refuses every enqueue
    write_reg(REG_MAX_ENTRIES, 5'd0);
    add_request(FUNC_ENQ, 8'd100, 32'h1234_5678);
    add_request(FUNC_DEQ, 8'd0, 32'h0);
    settle();

    // Capacity of one entry short of refusal, zero marks, ignored register index
    write_reg(REG_MAX_ENTRIES, 5'd2);
    write_reg(REG_HIGH_MARK, 5'd0);
    write_reg(REG_LOW_MARK, 5'd0);
    write_reg(REG_UNUSED, 5'd31);
    repeat (3) add_request(FUNC_ENQ, PRI_W'($urandom_range(0, 255)), $urandom);
    repeat (3) add_request(FUNC_DEQ, 8'd0, 32'h0);
    settle();

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_MAX_ENTRIES, 5'd31);
          write_reg(REG_HIGH_MARK, 5'd16);
          write_reg(REG_LOW_MARK, 5'd0);
        end
        1: begin
          write_reg(REG_MAX_ENTRIES, 5'd16);
          write_reg(REG_HIGH_MARK, 5'd31);
          write_reg(REG_LOW_MARK, 5'd31);
        end
        default: begin
          case ($urandom_range(0, 9))
            0: cap_val = 5'd0;
            1: cap_val = 5'd1;
            2: cap_val = 5'd31;
            3, 4, 5: cap_val = 5'd16;
            default: cap_val = CFG_W'($urandom_range(2, 15));
          endcase
          write_reg(REG_MAX_ENTRIES, cap_val);
          write_reg(REG_HIGH_MARK, pick_mark());
          write_reg(REG_LOW_MARK, pick_mark());
          if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 31)));
        end
      endcase
      calm = (p == 2);
      add_random(25, 85, p[0]);
      add_random(25, 15, p[0]);
      add_random(30, 50, $urandom_range(0, 1));
      // long receiver hold while requests keep coming
      if (p == 4)
        hold_asked++;
      settle();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
